FILE: sv/rthsv_pkg.sv
// shared types and constants for the rgb to hsv pixel core
`timescale 1ns / 1ps
package rthsv_pkg;

   localparam int CH_W            = 8;
   localparam int QUO_W           = 8;
   localparam int DIV_STAGES      = 4;
   localparam int STEPS_PER_STAGE = QUO_W / DIV_STAGES;
   localparam int NUM_W           = 16;
   localparam int DVS_W           = NUM_W - 1;
   localparam int HUE_WRAP        = 180;
   localparam int HUE_MAX         = HUE_WRAP - 1;

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } pix_type;

   typedef struct packed {
      logic [CH_W-1:0] hue;
      logic [CH_W-1:0] saturation;
      logic [CH_W-1:0] brightness;
   } hsv_type;

   typedef enum logic [2:0] {
      SEC_RED   = 3'b001,
      SEC_GREEN = 3'b010,
      SEC_BLUE  = 3'b100
   } sector_type;

   // one restoring divider lane: partial remainder, shifted divisor, quotient so far
   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [DVS_W-1:0] dvs;
      logic [QUO_W-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      div_lane_type    hue;
      div_lane_type    sat;
      logic            gray;
      logic            black;
      logic [CH_W-1:0] brightness;
   } div_type;

endpackage

FILE: sv/rthsv_prep.sv
// front stages: channel max and min, sector, and the two division operands
`timescale 1ns / 1ps
module rthsv_prep
   import rthsv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  pix_type in_data,
   output logic    in_hold,
   output logic    out_valid,
   output div_type out_data,
   input  logic    out_hold
);

   logic              s1_valid_ff;
   logic [CH_W-1:0]   s1_hi_ff;
   logic [CH_W-1:0]   s1_lo_ff;
   sector_type        s1_sec_ff;
   logic signed [8:0] s1_diff_ff;

   logic              s2_valid_ff;
   div_type           s2_data_ff;

   logic              s1_move;
   logic              s2_move;

   logic [CH_W-1:0]   hi_in;
   logic [CH_W-1:0]   lo_in;
   sector_type        sec_in;
   logic signed [8:0] diff_in;

   logic [CH_W-1:0]   chroma;
   logic [11:0]       base_d;
   logic [11:0]       tsum;
   logic [16:0]       t_ext;
   logic [16:0]       n30;
   logic [16:0]       d180;
   logic [16:0]       n_wrap;
   logic [NUM_W-1:0]  num_sat;
   div_type           s2_in;

   assign s2_move = !s2_valid_ff || !out_hold;
   assign s1_move = !s1_valid_ff || s2_move;
   assign in_hold = !s1_move;

   always_comb begin
      logic [CH_W-1:0] m;
      logic [CH_W-1:0] n;
      m = (in_data.red > in_data.green) ? in_data.red : in_data.green;
      hi_in = (m > in_data.blue) ? m : in_data.blue;
      n = (in_data.red < in_data.green) ? in_data.red : in_data.green;
      lo_in = (n < in_data.blue) ? n : in_data.blue;
      // ties go to red, then green
      if (hi_in == in_data.red) begin
         sec_in  = SEC_RED;
         diff_in = $signed({1'b0, in_data.green}) - $signed({1'b0, in_data.blue});
      end else if (hi_in == in_data.green) begin
         sec_in  = SEC_GREEN;
         diff_in = $signed({1'b0, in_data.blue}) - $signed({1'b0, in_data.red});
      end else begin
         sec_in  = SEC_BLUE;
         diff_in = $signed({1'b0, in_data.red}) - $signed({1'b0, in_data.green});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_move) begin
         s1_valid_ff <= in_valid;
      end
      if (s1_move && in_valid) begin
         s1_hi_ff   <= hi_in;
         s1_lo_ff   <= lo_in;
         s1_sec_ff  <= sec_in;
         s1_diff_ff <= diff_in;
      end
   end

   always_comb begin
      chroma = s1_hi_ff - s1_lo_ff;
      case (s1_sec_ff)
         SEC_RED:   base_d = 12'd0;
         SEC_GREEN: base_d = {3'b000, chroma, 1'b0};
         SEC_BLUE:  base_d = {2'b00, chroma, 2'b00};
         default:   base_d = 12'd0;
      endcase
      tsum   = base_d + {{3{s1_diff_ff[8]}}, s1_diff_ff};
      t_ext  = {{5{tsum[11]}}, tsum};
      // times thirty as two shifts, two's complement throughout
      n30    = (t_ext << 5) - (t_ext << 1);
      d180   = {9'b0, chroma} * 17'(HUE_WRAP);
      n_wrap = n30[16] ? (n30 + d180) : n30;
      // 255 * chroma
      num_sat = {chroma, 8'b0} - {8'b0, chroma};

      s2_in.hue.rem    = n_wrap[NUM_W-1:0];
      s2_in.hue.dvs    = {chroma, {(DVS_W-CH_W){1'b0}}};
      s2_in.hue.quo    = '0;
      s2_in.sat.rem    = num_sat;
      s2_in.sat.dvs    = {s1_hi_ff, {(DVS_W-CH_W){1'b0}}};
      s2_in.sat.quo    = '0;
      s2_in.gray       = (chroma == '0);
      s2_in.black      = (s1_hi_ff == '0);
      s2_in.brightness = s1_hi_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_move) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_move && s1_valid_ff) begin
         s2_data_ff <= s2_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

FILE: sv/rthsv_div_stage.sv
// one pipeline stage of the two restoring dividers, two quotient bits each
`timescale 1ns / 1ps
module rthsv_div_stage
   import rthsv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  div_type in_data,
   output logic    in_hold,
   output logic    out_valid,
   output div_type out_data,
   input  logic    out_hold
);

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;
   logic    move;

   function automatic div_lane_type div_step(input div_lane_type l);
      div_lane_type r;
      r = l;
      if ({1'b0, l.dvs} <= l.rem) begin
         r.rem = l.rem - {1'b0, l.dvs};
         r.quo = {l.quo[QUO_W-2:0], 1'b1};
      end else begin
         r.quo = {l.quo[QUO_W-2:0], 1'b0};
      end
      r.dvs = l.dvs >> 1;
      return r;
   endfunction

   always_comb begin
      data_in = in_data;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
         data_in.hue = div_step(data_in.hue);
         data_in.sat = div_step(data_in.sat);
      end
   end

   assign move    = !valid_ff || !out_hold;
   assign in_hold = !move;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (move) begin
         valid_ff <= in_valid;
      end
      if (move && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: sv/rgb_to_hsv_pixel_core.sv
// throughput: one pixel per cycle unless stalled, all seven register stages take a transfer per cycle
// each stage holds its own valid bit, so bubbles close up while rsp is stalled
// reset: synchronous, clears every stage valid bit; data registers are not reset
// top level: front stages, divider pipeline and output register
`timescale 1ns / 1ps
module rgb_to_hsv_pixel_core
   import rthsv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  pix_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output hsv_type rsp_data
);

   logic    div_valid [0:DIV_STAGES];
   div_type div_data  [0:DIV_STAGES];
   logic    div_hold  [0:DIV_STAGES];

   logic    rsp_valid_ff;
   hsv_type rsp_data_ff;
   hsv_type rsp_data_in;
   logic    out_move;

   rthsv_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_hold   (req_stall),
      .out_valid (div_valid[0]),
      .out_data  (div_data[0]),
      .out_hold  (div_hold[0])
   );

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      rthsv_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[g]),
         .in_data   (div_data[g]),
         .in_hold   (div_hold[g]),
         .out_valid (div_valid[g+1]),
         .out_data  (div_data[g+1]),
         .out_hold  (div_hold[g+1])
      );
   end

   assign out_move             = !rsp_valid_ff || !rsp_stall;
   assign div_hold[DIV_STAGES] = !out_move;

   always_comb begin
      rsp_data_in.hue        = div_data[DIV_STAGES].gray  ? '0 : div_data[DIV_STAGES].hue.quo;
      rsp_data_in.saturation = div_data[DIV_STAGES].black ? '0 : div_data[DIV_STAGES].sat.quo;
      rsp_data_in.brightness = div_data[DIV_STAGES].brightness;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_move) begin
         rsp_valid_ff <= div_valid[DIV_STAGES];
      end
      if (out_move && div_valid[DIV_STAGES]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_hue_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hue <= 8'(HUE_MAX)))
      else $error("hue out of range");

   a_black_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.brightness == '0) |->
         (rsp_data.saturation == '0 && rsp_data.hue == '0))
      else $error("black pixel with nonzero hue or saturation");

   a_gray_hue : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturation == '0) |-> (rsp_data.hue == '0))
      else $error("zero saturation with nonzero hue");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      (req_stall && !rsp_valid) |-> 1'b0)
      else $error("input stalled with nothing at the output");

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the rgb to hsv pixel core
`timescale 1ns / 1ps
module tb_top
   import rthsv_pkg::*;
();

   localparam int NUM_RANDOM   = 1000;
   localparam int IDLE_PCT     = 22;
   localparam int CALM_FIRST   = 400;
   localparam int CALM_LAST    = 700;
   localparam int HOLD_AT      = 450;
   localparam int HOLD_CYCLES  = 120;
   localparam int PAUSE_AT     = 200;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 20;
   localparam int MAX_PRINTS   = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   pix_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   hsv_type rsp_data;

   // shared between the two sides: no idling while calm, hold-off once asked
   bit calm      = 1'b0;
   bit hold_req  = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   rgb_to_hsv_pixel_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   class hsv_scoreboard;
      hsv_type expected_hsv[$];
      int      errors;
      int      checked;
      int      gray_seen;
      int      sector_seen[3];

      function new();
         errors    = 0;
         checked   = 0;
         gray_seen = 0;
         sector_seen = '{0, 0, 0};
      endfunction

      function int pending();
         return expected_hsv.size();
      endfunction

      task report(input string what);
         if (errors < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, what);
         errors++;
      endtask

      // fixed point hue: sector base and signed difference, wrapped by 180 chroma
      function hsv_type predict_hsv(pix_type p);
         int         hi;
         int         lo;
         int         chroma;
         int         base;
         int         diff;
         int         num;
         int         hue;
         int         sat;
         sector_type sec;
         hsv_type    res;
         hi  = p.red;
         if (p.green > hi) hi = p.green;
         if (p.blue > hi) hi = p.blue;
         lo  = p.red;
         if (p.green < lo) lo = p.green;
         if (p.blue < lo) lo = p.blue;
         chroma = hi - lo;
         sat = (hi != 0) ? (255 * chroma) / hi : 0;
         hue = 0;
         if (chroma != 0) begin
            // red wins ties, then green
            if (hi == p.red) sec = SEC_RED;
            else if (hi == p.green) sec = SEC_GREEN;
            else sec = SEC_BLUE;
            case (sec)
               SEC_RED: begin
                  base = 0;
                  diff = int'(p.green) - int'(p.blue);
                  sector_seen[0]++;
               end
               SEC_GREEN: begin
                  base = 2;
                  diff = int'(p.blue) - int'(p.red);
                  sector_seen[1]++;
               end
               default: begin
                  base = 4;
                  diff = int'(p.red) - int'(p.green);
                  sector_seen[2]++;
               end
            endcase
            num = 30 * (base * chroma + diff);
            if (num < 0) num += HUE_WRAP * chroma;
            hue = num / chroma;
         end else begin
            gray_seen++;
         end
         res.hue        = CH_W'(hue);
         res.saturation = CH_W'(sat);
         res.brightness = CH_W'(hi);
         return res;
      endfunction

      function void note_pixel(pix_type p);
         expected_hsv.push_back(predict_hsv(p));
      endfunction

      task check_hsv(input hsv_type got);
         hsv_type want;
         if (expected_hsv.size() == 0) begin
            report($sformatf("unexpected result h=%0d s=%0d v=%0d",
                             got.hue, got.saturation, got.brightness));
         end else begin
            want = expected_hsv.pop_front();
            checked++;
            if (got.hue !== want.hue)
               report($sformatf("hue got %0d want %0d", got.hue, want.hue));
            if (got.saturation !== want.saturation)
               report($sformatf("saturation got %0d want %0d",
                                got.saturation, want.saturation));
            if (got.brightness !== want.brightness)
               report($sformatf("brightness got %0d want %0d",
                                got.brightness, want.brightness));
         end
      endtask
   endclass

   hsv_scoreboard sb;
   int            pixels_sent = 0;

   function automatic pix_type mk_pixel(int b, int g, int r);
      pix_type p;
      p.blue  = CH_W'(b);
      p.green = CH_W'(g);
      p.red   = CH_W'(r);
      return p;
   endfunction

   // mostly uniform, with grays, ties for the maximum and saturated channels
   function automatic pix_type rand_pixel();
      int      mode;
      int      a;
      int      c;
      pix_type p;
      mode = $urandom_range(9);
      a    = $urandom_range(255);
      c    = $urandom_range(255);
      p    = mk_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
      case (mode)
         0: p = mk_pixel(a, a, a);
         1: begin
            if (c > a) begin
               a = c;
               c = $urandom_range(a);
            end
            case ($urandom_range(2))
               0: p = mk_pixel(c, a, a);
               1: p = mk_pixel(a, a, c);
               default: p = mk_pixel(a, c, a);
            endcase
         end
         2: begin
            p.red   = ($urandom_range(1) != 0) ? 8'hff : 8'h00;
            p.blue  = ($urandom_range(1) != 0) ? 8'hff : p.blue;
         end
         3: p.green = ($urandom_range(1) != 0) ? 8'h00 : 8'hff;
         default: ;
      endcase
      return p;
   endfunction

   task automatic send_pixel(input pix_type p);
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      sb.note_pixel(p);
      pixels_sent++;
   endtask

   task automatic idle_gap();
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   // receiver: check every transfer, then choose the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_hsv(rsp_data);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         hold_done <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < IDLE_PCT);
      end
   end

   initial begin
      pix_type directed[$];
      int      drain;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = '{
         mk_pixel(0, 0, 0),       mk_pixel(255, 255, 255), mk_pixel(77, 77, 77),
         mk_pixel(1, 1, 1),       mk_pixel(0, 0, 255),     mk_pixel(0, 255, 0),
         mk_pixel(255, 0, 0),     mk_pixel(0, 255, 255),   mk_pixel(255, 255, 0),
         mk_pixel(255, 0, 255),   mk_pixel(200, 10, 255),  mk_pixel(10, 200, 255),
         mk_pixel(1, 0, 255),     mk_pixel(0, 0, 1),       mk_pixel(254, 254, 255),
         mk_pixel(255, 0, 1),     mk_pixel(1, 1, 0),       mk_pixel(30, 200, 90),
         mk_pixel(90, 200, 30),   mk_pixel(200, 30, 90),   mk_pixel(200, 90, 30),
         mk_pixel(128, 127, 128)
      };
      foreach (directed[k]) begin
         send_pixel(directed[k]);
         idle_gap();
      end

      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i == PAUSE_AT) begin
            // sender waits for the pipeline to empty completely
            req_valid <= 1'b0;
            while (sb.pending() > 0) @(posedge clock);
         end
         if (i == CALM_FIRST) calm <= 1'b1;
         if (i == CALM_LAST) calm <= 1'b0;
         if (i == HOLD_AT) hold_req <= 1'b1;
         send_pixel(rand_pixel());
         idle_gap();
      end
      req_valid <= 1'b0;

      drain = 0;
      while (sb.pending() > 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() > 0)
         sb.report($sformatf("%0d results never arrived", sb.pending()));

      $display("covered %0d pixels, %0d results checked, %0d gray", pixels_sent,
               sb.checked, sb.gray_seen);
      $display("sectors red %0d green %0d blue %0d, one output hold-off of %0d cycles",
               sb.sector_seen[0], sb.sector_seen[1], sb.sector_seen[2], HOLD_CYCLES);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
